### rtl/ppd_pkg.sv
// ----------------------------------------------------------------------------
// ppd_pkg - shared types and constants for the positional PID block
// Field widths, datapath widths, register indexes and control structs.
// ----------------------------------------------------------------------------
package ppd_pkg;

  localparam int VAL_W  = 16;  // setpoint / measurement
  localparam int ERR_W  = 17;  // error
  localparam int DIF_W  = 18;  // error delta
  localparam int GAIN_W = 16;  // Q8.8 gains
  localparam int DB_W   = 15;  // deadband
  localparam int SUM_W  = 32;  // integral
  localparam int PROD_W = GAIN_W + 1 + SUM_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int DRV_W  = 15;  // drive field
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
  localparam logic [IDX_W-1:0] REG_DERIV_GAIN = 2'd2;
  localparam logic [IDX_W-1:0] REG_DEAD_BAND  = 2'd3;

  typedef struct packed {
    logic clr;     // zero the accumulator
    logic mul_en;  // register a new product
    logic acc_en;  // add the held product
  } mac_ctrl_t;

endpackage

### rtl/ppd_ifs.sv
// ----------------------------------------------------------------------------
// ppd_ifs - valid/ready channels of the positional PID block
// Input channel carries setpoint and measurement, output channel the drive.
// ----------------------------------------------------------------------------
interface ppd_in_if;
  import ppd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] target_value;
  logic signed [VAL_W-1:0] measured_value;

  modport source (output valid, output target_value, output measured_value, input ready);
  modport sink   (input valid, input target_value, input measured_value, output ready);
endinterface

interface ppd_out_if;
  import ppd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DRV_W-1:0] drive_value;
  logic                    outside_deadband;

  modport source (output valid, output drive_value, output outside_deadband, input ready);
  modport sink   (input valid, input drive_value, input outside_deadband, output ready);
endinterface

### rtl/ppd_div.sv
// ----------------------------------------------------------------------------
// ppd_div - restoring divider, one quotient bit per cycle
// Unsigned dividend over unsigned divisor; pulses done with the quotient.
// ----------------------------------------------------------------------------
module ppd_div #(
  parameter int DVD_W = 23,
  parameter int DVS_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  assign trial = {rem_r, q_r[DVD_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
      rem_nxt  = '0;
      q_nxt    = dividend;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = diff[DVS_W-1:0];
        q_nxt   = DVD_W'({q_r, 1'b1});
      end else begin
        rem_nxt = trial[DVS_W-1:0];
        q_nxt   = DVD_W'({q_r, 1'b0});
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

### rtl/ppd_mac.sv
// ----------------------------------------------------------------------------
// ppd_mac - shared gain multiplier and accumulator
// Product registered, then added to the accumulator on a later cycle.
// ----------------------------------------------------------------------------
module ppd_mac (
  input  logic                         clk,
  input  ppd_pkg::mac_ctrl_t           ctrl,
  input  logic [ppd_pkg::GAIN_W-1:0]   gain,
  input  logic signed [ppd_pkg::SUM_W-1:0] opnd,
  output logic signed [ppd_pkg::ACC_W-1:0] acc
);
  import ppd_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]  acc_r;

  assign prod_nxt = $signed({1'b0, gain}) * opnd;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign acc = acc_r;

endmodule

### rtl/positional_pid_deadband.sv
// ----------------------------------------------------------------------------
// positional_pid_deadband - positional PID controller with deadband
// Integral anti-windup clamp, Q8.8 gains, clamped drive output.
// ----------------------------------------------------------------------------
// Each input transaction (setpoint, measurement) yields one output
// transaction (drive, outside_deadband). The error is setpoint minus
// measurement, zeroed when strictly inside +/-dead_band. It is added to a
// saturating 32-bit integral; with a nonzero integral gain the integral is
// clamped to +/- (OUT_LIMIT << GAIN_FRAC_BITS) / integ_gain, truncated. The
// drive is (kp*e + ki*sum + kd*(e - e_prev)) >> GAIN_FRAC_BITS, floored, and
// clamped to +/-OUT_LIMIT. Timing: one transaction is processed at a time,
// stepping through the states DB, SUM, DIV and CLAMP (the last two only with
// integ_gain nonzero), then MUL and ACC for each of the P, I and D terms, and
// OUT, which loads the output register. The length of the sequence is set by
// the bit-serial divider for the clamp limit (DVD_W = clog2(OUT_LIMIT+1) +
// GAIN_FRAC_BITS quotient bits) and by the single multiplier shared by the
// three terms; the last step also holds while the previous result has not
// been taken.
// in_ch.ready is high only while the sequencer is idle; a finished
// result sits in the output register and the next transaction is accepted
// while it waits. Configuration is written through cfg_we/cfg_index/
// cfg_data and must only change while the block is idle.
module positional_pid_deadband #(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int OUT_LIMIT      = 8400
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ppd_in_if.sink                       in_ch,
  ppd_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [ppd_pkg::IDX_W-1:0]    cfg_index,
  input  logic [ppd_pkg::GAIN_W-1:0]   cfg_data
);
  import ppd_pkg::*;

  localparam int LIM_W = $clog2(OUT_LIMIT + 1);
  localparam int DVD_W = LIM_W + GAIN_FRAC_BITS;
  localparam logic [DVD_W-1:0] LIM_DVD = DVD_W'(OUT_LIMIT) << GAIN_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] DRV_MAX = ACC_W'(OUT_LIMIT);
  localparam logic signed [ACC_W-1:0] DRV_MIN = -ACC_W'(OUT_LIMIT);
  localparam logic signed [SUM_W:0]   SUM_MAX = {2'b00, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W:0]   SUM_MIN = {2'b11, {(SUM_W-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_DB, S_SUM, S_DIV, S_CLAMP, S_MUL, S_ACC, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    OP_P, OP_I, OP_D
  } mac_op_t;

  // configuration
  logic [GAIN_W-1:0] kp_r, ki_r, kd_r;
  logic [DB_W-1:0]   db_r;

  // sequencer and datapath state
  state_t                   state_r;
  mac_op_t                  op_r;
  logic signed [ERR_W-1:0]  err_r;
  logic                     flag_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  integ_r;
  logic signed [ERR_W-1:0]  eprev_r;
  logic                     out_valid_r;

  logic signed [ERR_W-1:0]  db_s;
  logic                     in_band;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [SUM_W-1:0]  sum_sat;
  logic signed [SUM_W-1:0]  lim_s;
  logic signed [DIF_W-1:0]  err_dif;
  logic                     in_fire;
  logic                     out_free;

  // shared units
  mac_ctrl_t                mac_ctrl;
  logic [GAIN_W-1:0]        mac_gain;
  logic signed [SUM_W-1:0]  mac_opnd;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_shr;
  logic signed [ACC_W-1:0]  drv_clamp;
  logic                     div_start;
  logic                     div_done;
  logic [DVD_W-1:0]         div_quot;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // deadband: strictly inside +/-db zeroes the error
  assign db_s    = $signed({2'b00, db_r});
  assign in_band = (err_r < db_s) && (err_r > -db_s);

  // saturating integral update
  assign sum_wide = (SUM_W+1)'(integ_r) + (SUM_W+1)'(err_r);
  always_comb begin
    if (sum_wide > SUM_MAX) begin
      sum_sat = SUM_MAX[SUM_W-1:0];
    end else if (sum_wide < SUM_MIN) begin
      sum_sat = SUM_MIN[SUM_W-1:0];
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  // anti-windup limit, quotient is always positive and narrower than SUM_W
  assign lim_s = $signed(SUM_W'(div_quot));

  assign err_dif = DIF_W'(err_r) - DIF_W'(eprev_r);

  // operand select for the shared multiplier
  always_comb begin
    case (op_r)
      OP_P: begin
        mac_gain = kp_r;
        mac_opnd = SUM_W'(err_r);
      end
      OP_I: begin
        mac_gain = ki_r;
        mac_opnd = sum_r;
      end
      OP_D: begin
        mac_gain = kd_r;
        mac_opnd = SUM_W'(err_dif);
      end
      default: begin
        mac_gain = '0;
        mac_opnd = '0;
      end
    endcase
  end

  always_comb begin
    mac_ctrl.clr    = (state_r == S_SUM);
    mac_ctrl.mul_en = (state_r == S_MUL);
    mac_ctrl.acc_en = (state_r == S_ACC);
  end

  assign div_start = (state_r == S_SUM) && (ki_r != '0);

  // floor shift, then clamp to the output limit
  assign acc_shr = acc >>> GAIN_FRAC_BITS;
  always_comb begin
    if (acc_shr > DRV_MAX) begin
      drv_clamp = DRV_MAX;
    end else if (acc_shr < DRV_MIN) begin
      drv_clamp = DRV_MIN;
    end else begin
      drv_clamp = acc_shr;
    end
  end

  ppd_div #(
    .DVD_W (DVD_W),
    .DVS_W (GAIN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (LIM_DVD),
    .divisor  (ki_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  ppd_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .gain (mac_gain),
    .opnd (mac_opnd),
    .acc  (acc)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= '0;
      ki_r <= '0;
      kd_r <= '0;
      db_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP_GAIN:  kp_r <= cfg_data;
        REG_INTEG_GAIN: ki_r <= cfg_data;
        REG_DERIV_GAIN: kd_r <= cfg_data;
        REG_DEAD_BAND:  db_r <= cfg_data[DB_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_P;
      integ_r     <= '0;
      eprev_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // S_OUT reloads the output register itself
      if (out_valid_r && out_ch.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            err_r   <= ERR_W'(in_ch.target_value) - ERR_W'(in_ch.measured_value);
            state_r <= S_DB;
          end
        end
        S_DB: begin
          flag_r <= !in_band;
          if (in_band) begin
            err_r <= '0;
          end
          state_r <= S_SUM;
        end
        S_SUM: begin
          sum_r   <= sum_sat;
          op_r    <= OP_P;
          state_r <= (ki_r != '0) ? S_DIV : S_MUL;
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          if (sum_r > lim_s) begin
            sum_r <= lim_s;
          end else if (sum_r < -lim_s) begin
            sum_r <= -lim_s;
          end
          state_r <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (op_r == OP_D) begin
            state_r <= S_OUT;
          end else begin
            op_r    <= (op_r == OP_P) ? OP_I : OP_D;
            state_r <= S_MUL;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_ch.drive_value      <= drv_clamp[DRV_W-1:0];
            out_ch.outside_deadband <= flag_r;
            out_valid_r             <= 1'b1;
            integ_r                 <= sum_r;
            eprev_r                 <= err_r;
            state_r                 <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the positional PID controller with deadband
// Drives setpoint/measurement transactions with random gaps and output
// stalls, predicts drive and deadband flag per transaction, and checks the
// results in order.
// ----------------------------------------------------------------------------
module tb;
  import ppd_pkg::*;

  localparam int FRAC         = 8;     // Q8.8 gains
  localparam int OUT_LIM      = 8400;  // drive clamp
  localparam int QUIET_LIMIT  = 2000;  // cycles with no transaction at all
  localparam int RAND_ITEMS   = 1350;
  localparam longint SUM_MAX  = 64'sd2147483647;
  localparam longint SUM_MIN  = -64'sd2147483648;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 16'h7FFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 16'h8000;

  // expected output transaction
  typedef struct {
    logic signed [DRV_W-1:0] drive;
    logic                    outside;
  } drive_res_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of gains, deadband, previous error and integral.
  // note_input runs one controller step per accepted input transaction and
  // queues the drive it implies; check_output pops and compares.
  // --------------------------------------------------------------------------
  class pid_scoreboard;
    logic [GAIN_W-1:0] kp, ki, kd;
    logic [DB_W-1:0]   dband;
    longint            err_last;
    longint            integ;
    drive_res_t        drive_q[$];
    int                errors, checked, zeroed, sat_hits;

    function new();
      kp = '0; ki = '0; kd = '0; dband = '0;
      err_last = 0; integ = 0;
      errors = 0; checked = 0; zeroed = 0; sat_hits = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
      case (idx)
        REG_PROP_GAIN:  kp = data;
        REG_INTEG_GAIN: ki = data;
        REG_DERIV_GAIN: kd = data;
        REG_DEAD_BAND:  dband = data[DB_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic signed [VAL_W-1:0] tgt, logic signed [VAL_W-1:0] meas);
      longint     e, s, lim, acc, drv;
      drive_res_t r;
      e = longint'(tgt) - longint'(meas);
      r.outside = 1'b1;
      // strictly inside the band: error dropped
      if (e < longint'(dband) && e > -longint'(dband)) begin
        e = 0;
        r.outside = 1'b0;
        zeroed++;
      end
      s = integ + e;
      if (s > SUM_MAX || s < SUM_MIN) sat_hits++;
      if (s > SUM_MAX) s = SUM_MAX;
      if (s < SUM_MIN) s = SUM_MIN;
      // anti-windup, only with a live integral gain
      if (ki != 0) begin
        lim = (longint'(OUT_LIM) <<< FRAC) / longint'(ki);
        if (s > lim) s = lim;
        if (s < -lim) s = -lim;
      end
      integ = s;
      acc = longint'(kp) * e + longint'(ki) * s + longint'(kd) * (e - err_last);
      err_last = e;
      drv = acc >>> FRAC;  // arithmetic shift floors
      if (drv > OUT_LIM) drv = OUT_LIM;
      if (drv < -OUT_LIM) drv = -OUT_LIM;
      r.drive = drv[DRV_W-1:0];
      drive_q.push_back(r);
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 30) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_output(input logic signed [DRV_W-1:0] drv, input logic flag);
      drive_res_t want;
      if (drive_q.size() == 0) begin
        report($sformatf("unexpected result drive=%0d flag=%0b", drv, flag));
        return;
      end
      want = drive_q.pop_front();
      checked++;
      if (drv !== want.drive)
        report($sformatf("drive %0d, want %0d", drv, want.drive));
      if (flag !== want.outside)
        report($sformatf("outside_deadband %0b, want %0b", flag, want.outside));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // --------------------------------------------------------------------------
  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [GAIN_W-1:0] cfg_data;

  ppd_in_if  in_ch ();
  ppd_out_if out_ch ();

  pid_scoreboard sb = new();

  bit idle_on = 1'b1;   // both sides insert random gaps when set
  int items_sent = 0;
  int cfg_phases = 0;

  positional_pid_deadband #(
    .GAIN_FRAC_BITS (FRAC),
    .OUT_LIMIT      (OUT_LIM)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Driver tasks. Everything is driven with NBAs right after a rising edge;
  // handshake signals are sampled right after the edge, i.e. the values the
  // DUT saw at that edge.
  // --------------------------------------------------------------------------

  // one register write; cfg_we stays high across back-to-back writes
  task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // full register set; only called with the block idle
  task automatic write_config(input logic [GAIN_W-1:0] kp_v, input logic [GAIN_W-1:0] ki_v,
                              input logic [GAIN_W-1:0] kd_v, input logic [DB_W-1:0] db_v);
    put_reg(REG_PROP_GAIN, kp_v);
    put_reg(REG_INTEG_GAIN, ki_v);
    put_reg(REG_DERIV_GAIN, kd_v);
    put_reg(REG_DEAD_BAND, {1'b0, db_v});
    cfg_we <= 1'b0;
    cfg_phases++;
  endtask

  // valid is left high after acceptance so a zero-gap follower never
  // drops and re-raises it in the same step
  task automatic send_item(input logic signed [VAL_W-1:0] tgt,
                           input logic signed [VAL_W-1:0] meas);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.target_value   <= tgt;
    in_ch.measured_value <= meas;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_input(tgt, meas);
    items_sent++;
  endtask

  // stop sending and wait for every queued drive to come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.drive_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] corner_val();
    case ($urandom_range(0, 4))
      0:       return VAL_MIN;
      1:       return -16'sd1;
      2:       return 16'sd0;
      3:       return 16'sd1;
      default: return VAL_MAX;
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'($urandom_range(1, 16));
      3:       return GAIN_W'($urandom_range(0, 1023));
      default: return GAIN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [DB_W-1:0] pick_band();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return DB_W'($urandom_range(1, 64));
      default: return DB_W'($urandom_range(0, 4000));
    endcase
  endfunction

  // mostly full-range values, plenty of errors right at the band edge
  task automatic random_item();
    int t_i, m_i, off;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        send_item(VAL_W'($urandom), VAL_W'($urandom));
      end
      4, 5, 6, 7: begin
        t_i = int'($urandom_range(0, 65535)) - 32768;
        off = int'(sb.dband) + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1) == 1) off = -off;
        m_i = t_i - off;
        if (m_i > 32767) m_i = 32767;
        if (m_i < -32768) m_i = -32768;
        send_item(VAL_W'(t_i), VAL_W'(m_i));
      end
      default: begin
        send_item(corner_val(), corner_val());
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall per transaction, then check in order.
  // ready is only lowered when a stall is drawn, so it never toggles twice
  // in one step.
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = idle_on ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      sb.check_output(out_ch.drive_value, out_ch.outside_deadband);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any stretch with no transaction on either channel this long
  // means the block hung.
  // --------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    do @(posedge clk); while (rst_n !== 1'b1);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int rand_goal, n;

    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= REG_PROP_GAIN;
    cfg_data             <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.target_value   <= '0;
    in_ch.measured_value <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: all gains zero, zero deadband -> flag always set
    send_item(VAL_MAX, VAL_MIN);
    send_item(VAL_MIN, VAL_MAX);
    send_item(16'sd0, 16'sd0);
    drain();

    // unity kp, band of 100: both band edges, just inside, zero error
    write_config(16'd256, 16'd0, 16'd0, 15'd100);
    send_item(16'sd100, 16'sd0);
    send_item(16'sd0, -16'sd99);
    send_item(-16'sd100, 16'sd0);
    send_item(16'sd0, 16'sd99);
    send_item(16'sd7, 16'sd7);
    drain();

    // tiny kp + huge kd: floor of negative products, drive clamp both ways
    write_config(16'd1, 16'd0, 16'hFFFF, 15'd0);
    send_item(16'sd0, 16'sd1);
    send_item(VAL_MAX, VAL_MIN);
    send_item(VAL_MIN, VAL_MAX);
    send_item(16'sd5, 16'sd5);
    drain();

    // every register at its top value; error equal to -band is kept
    write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF);
    send_item(VAL_MAX, VAL_MIN);
    send_item(16'sd0, VAL_MAX);
    send_item(16'sd0, 16'sd32766);
    send_item(VAL_MIN, VAL_MAX);
    drain();

    // integral-only: anti-windup clamp hit from both sides
    write_config(16'd0, 16'd200, 16'd0, 15'd0);
    send_item(VAL_MAX, VAL_MIN);
    send_item(VAL_MAX, VAL_MIN);
    send_item(VAL_MIN, VAL_MAX);
    send_item(VAL_MIN, VAL_MAX);
    drain();

    // random phases: fresh register set each time, a quarter of them with
    // no idling on either side
    rand_goal = items_sent + RAND_ITEMS;
    while (items_sent < rand_goal) begin
      write_config(pick_gain(), pick_gain(), pick_gain(), pick_band());
      idle_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(40, 160);
      repeat (n) random_item();
      drain();
    end
    idle_on = 1'b1;

    drain();
    repeat (50) @(posedge clk);
    if (sb.drive_q.size() != 0)
      sb.report($sformatf("%0d expected results never came", sb.drive_q.size()));

    $display("Ran %0d transactions over %0d register settings, %0d results checked.",
             items_sent, cfg_phases, sb.checked);
    $display("Errors zeroed by the deadband: %0d, integral hits on the 32-bit limits: %0d.",
             sb.zeroed, sb.sat_hits);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### positional_pid_deadband.f
rtl/ppd_pkg.sv
rtl/ppd_ifs.sv
rtl/ppd_div.sv
rtl/ppd_mac.sv
rtl/positional_pid_deadband.sv
test/tb.sv
